[rtl/ppp_fe_pkg.sv]
// Shared types, line constants and FCS-16 helpers for the PPP async frame encoder.
// No dependencies; imported by every module of the encoder.
`default_nettype none

package ppp_fe_pkg;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7e;
    localparam logic [7:0]  ESC_BYTE   = 8'h7d;
    localparam logic [7:0]  TRANS_MASK = 8'h20;
    localparam logic [7:0]  ADDR_BYTE  = 8'hff;
    localparam logic [7:0]  CTRL_BYTE  = 8'h03;
    localparam logic [15:0] FCS_INIT   = 16'hffff;
    localparam logic [15:0] FCS_POLY   = 16'h8408;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Bitwise reflected CRC over one byte.
    function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] data);
        logic [15:0] f;
        f = fcs ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
        end
        return f;
    endfunction

    function automatic logic needs_esc(input logic [7:0] data);
        return (data < TRANS_MASK) || (data == FLAG_BYTE) || (data == ESC_BYTE);
    endfunction

    // FCS after address and control, the starting point of every frame's payload.
    localparam logic [15:0] FCS_OPEN = fcs_update(fcs_update(FCS_INIT, ADDR_BYTE), CTRL_BYTE);

    // One classified item handed from front to back.
    typedef struct packed {
        logic        open;   // item opens a new frame
        logic        last;   // item closes the frame
        logic [7:0]  data;
        logic [15:0] fcs;    // complemented FCS, meaningful when last
    } fe_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OPEN_FLAG,
        ST_ADDR,
        ST_CTRL_ESC,
        ST_CTRL,
        ST_DATA,
        ST_FCS_LO,
        ST_FCS_HI,
        ST_CLOSE
    } bk_state_t;

endpackage

`default_nettype wire

[rtl/ppp_fe_front.sv]
// Front end: accepts payload items, tracks frame state and running FCS-16.
// Depends on ppp_fe_pkg.
`default_nettype none

module ppp_fe_front (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire [7:0]              s_tdata,   // [7:0] payload_byte
    input  wire                    s_tlast,   // packet_end
    output logic                   wr_valid,
    output ppp_fe_pkg::fe_entry_t  wr_entry,
    input  wire                    wr_ready
);
    import ppp_fe_pkg::*;

    logic        in_frame_reg, in_frame_next;
    logic [15:0] fcs_reg, fcs_next;
    logic [15:0] fcs_base;
    logic [15:0] fcs_new;
    logic        accept;

    assign s_tready = wr_ready;
    assign wr_valid = s_tvalid;
    assign accept   = s_tvalid && wr_ready;

    always_comb
    begin
        fcs_base = in_frame_reg ? fcs_reg : FCS_OPEN;
        fcs_new  = fcs_update(fcs_base, s_tdata);

        wr_entry.open = !in_frame_reg;
        wr_entry.last = s_tlast;
        wr_entry.data = s_tdata;
        wr_entry.fcs  = ~fcs_new;

        in_frame_next = in_frame_reg;
        fcs_next      = fcs_reg;
        if (accept)
        begin
            in_frame_next = !s_tlast;
            fcs_next      = s_tlast ? FCS_INIT : fcs_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            fcs_reg      <= FCS_INIT;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            fcs_reg      <= fcs_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ppp_fe_queue.sv]
// Small register FIFO of classified items between front and back.
// Depends on ppp_fe_pkg.
`default_nettype none

module ppp_fe_queue #(
    parameter int DEPTH = ppp_fe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    wr_valid,
    input  ppp_fe_pkg::fe_entry_t  wr_entry,
    output logic                   wr_ready,
    output logic                   rd_valid,
    output ppp_fe_pkg::fe_entry_t  rd_entry,
    input  wire                    rd_pop
);
    import ppp_fe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fe_entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ppp_fe_back.sv]
// Back end: sequences opening header, stuffed payload, FCS, closing flag to
// an output register, one byte per cycle unless stalled. Uses ppp_fe_pkg.
`default_nettype none

module ppp_fe_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    rd_valid,
    input  ppp_fe_pkg::fe_entry_t  rd_entry,
    output logic                   rd_pop,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [7:0]             m_tdata,   // [7:0] line_byte
    output logic                   m_tlast,   // run_last
    output logic                   m_tuser    // frame_done
);
    import ppp_fe_pkg::*;

    bk_state_t   st_reg, st_next, st_cur;
    logic        esc_reg, esc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;
    logic        out_done_reg, out_done_next;
    logic        advance;
    logic [7:0]  cur_byte;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

    assign advance = rd_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        // at the head of a new item, start straight away
        if (st_reg == ST_IDLE)
            st_cur = rd_entry.open ? ST_OPEN_FLAG : ST_DATA;
        else
            st_cur = st_reg;

        unique case (st_cur)
            ST_FCS_LO: cur_byte = rd_entry.fcs[7:0];
            ST_FCS_HI: cur_byte = rd_entry.fcs[15:8];
            default:   cur_byte = rd_entry.data;
        endcase

        st_next        = st_reg;
        esc_next       = esc_reg;
        rd_pop         = 1'b0;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            out_done_next  = 1'b0;
            esc_next       = 1'b0;
            unique case (st_cur)
                ST_OPEN_FLAG:
                begin
                    out_data_next = FLAG_BYTE;
                    st_next       = ST_ADDR;
                end
                ST_ADDR:
                begin
                    out_data_next = ADDR_BYTE;
                    st_next       = ST_CTRL_ESC;
                end
                ST_CTRL_ESC:
                begin
                    out_data_next = ESC_BYTE;
                    st_next       = ST_CTRL;
                end
                ST_CTRL:
                begin
                    out_data_next = CTRL_BYTE ^ TRANS_MASK;
                    st_next       = ST_DATA;
                end
                ST_DATA, ST_FCS_LO, ST_FCS_HI:
                begin
                    if (needs_esc(cur_byte) && !esc_reg)
                    begin
                        out_data_next = ESC_BYTE;
                        esc_next      = 1'b1;
                        st_next       = st_cur;
                    end
                    else
                    begin
                        out_data_next = esc_reg ? (cur_byte ^ TRANS_MASK) : cur_byte;
                        if (st_cur == ST_FCS_LO)
                            st_next = ST_FCS_HI;
                        else if (st_cur == ST_FCS_HI)
                            st_next = ST_CLOSE;
                        else if (rd_entry.last)
                            st_next = ST_FCS_LO;
                        else
                        begin
                            out_last_next = 1'b1;
                            rd_pop        = 1'b1;
                            st_next       = ST_IDLE;
                        end
                    end
                end
                ST_CLOSE:
                begin
                    out_data_next = FLAG_BYTE;
                    out_last_next = 1'b1;
                    out_done_next = 1'b1;
                    rd_pop        = 1'b1;
                    st_next       = ST_IDLE;
                end
                default:
                begin
                    out_valid_next = out_valid_reg;
                    st_next        = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            esc_reg       <= esc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

endmodule

`default_nettype wire

[rtl/ppp_async_frame_encoder.sv]
// PPP async HDLC-like frame encoder with FCS-16: front classifier, item queue, byte sequencer.
// An accepted item is written into the queue; its first line byte is then registered at the back end's output.
// Throughput: one line byte per cycle from the back sequencer while the output is not stalled; an item yields 1 to 11
// line bytes there (1 for an unstuffed mid-frame byte, 2 if stuffed, up to 11 for a
// one-byte packet). The front accepts one item per cycle while the queue has room.
// Reset (rst_n low, async): no frame open, FCS at FFFF, queue empty, output invalid.
`default_nettype none

module ppp_async_frame_encoder #(
    parameter int QUEUE_DEPTH = ppp_fe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [7:0]   s_tdata,   // [7:0] payload_byte
    input  wire         s_tlast,   // packet_end
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] line_byte
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // frame_done
);
    import ppp_fe_pkg::*;

    logic       wr_valid, wr_ready;
    fe_entry_t  wr_entry;
    logic       rd_valid, rd_pop;
    fe_entry_t  rd_entry;

    ppp_fe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .wr_valid (wr_valid),
        .wr_entry (wr_entry),
        .wr_ready (wr_ready)
    );

    ppp_fe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_entry (wr_entry),
        .wr_ready (wr_ready),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry),
        .rd_pop   (rd_pop)
    );

    ppp_fe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry),
        .rd_pop   (rd_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

[rtl/ppp_fe_checker.sv]
// Port-level checks for the PPP async frame encoder, bound to the top level.
// Depends on ppp_fe_pkg for the line constants.
`default_nettype none

module ppp_fe_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [7:0]  m_tdata,
    input  wire        m_tlast,
    input  wire        m_tuser
);
    import ppp_fe_pkg::*;

    // closing flag is always the final byte of its item
    a_done_is_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == FLAG_BYTE))
        else $error("frame_done on a byte other than a final closing flag");

    // an escape byte is never marked as the final byte of an item or of a frame
    a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == ESC_BYTE) |-> !m_tlast && !m_tuser)
        else $error("escape byte marked as final result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid straight out of reset");

endmodule

bind ppp_async_frame_encoder ppp_fe_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
